[design/irpfd_pkg.sv]
// shared types and constants for the ir pulse frame decoder
package irpfd_pkg;

    localparam int TICK_W   = 8;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 8;
    localparam int NUM_STORE = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MAX = 3'd5;

    localparam logic [TICK_W-1:0] RST_ZERO_MIN   = 8'd5;
    localparam logic [TICK_W-1:0] RST_ZERO_MAX   = 8'd40;
    localparam logic [TICK_W-1:0] RST_ONE_MIN    = 8'd40;
    localparam logic [TICK_W-1:0] RST_ONE_MAX    = 8'd99;
    localparam logic [TICK_W-1:0] RST_LEADER_MIN = 8'd180;
    localparam logic [TICK_W-1:0] RST_LEADER_MAX = 8'd220;

    localparam logic [2:0] LAST_BIT  = 3'd7;
    localparam logic [1:0] LAST_BYTE = 2'd3;

    typedef struct packed {
        logic [TICK_W-1:0] zero_min;
        logic [TICK_W-1:0] zero_max;
        logic [TICK_W-1:0] one_min;
        logic [TICK_W-1:0] one_max;
        logic [TICK_W-1:0] leader_min;
        logic [TICK_W-1:0] leader_max;
    } window_cfg_t;

    typedef struct packed {
        logic is_leader;
        logic is_zero;
        logic is_one;
    } pulse_class_t;

endpackage

[design/irpfd_classify.sv]
// pulse duration classifier against the leader, zero and one windows
module irpfd_classify
(
    input  logic [irpfd_pkg::TICK_W-1:0] ticks,
    input  irpfd_pkg::window_cfg_t       win,
    output irpfd_pkg::pulse_class_t      cls
);

    // all window bounds are exclusive
    always_comb
    begin
        cls.is_leader = (ticks > win.leader_min) && (ticks < win.leader_max);
        cls.is_zero   = (ticks > win.zero_min) && (ticks < win.zero_max);
        cls.is_one    = (ticks > win.one_min) && (ticks < win.one_max);
    end

endmodule

[design/ir_pulse_frame_decoder_core.sv]
// ir pulse frame decoder: leader detect, bit classification, four-byte frame assembly
// a pulse is captured in the input register; a completed frame then goes to the result register
// throughput: one pulse per cycle while the result register is free or being emptied
// a frame waiting in the result register stalls the input until it is taken
// reset: asynchronous active low; clears control state and loads the default windows
// the three stored bytes are not reset, they are always written before a frame is sent
module ir_pulse_frame_decoder_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [irpfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irpfd_pkg::CFG_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [irpfd_pkg::TICK_W-1:0]       high_ticks,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [irpfd_pkg::BYTE_W-1:0]       frame_byte0,
    output logic [irpfd_pkg::BYTE_W-1:0]       frame_byte1,
    output logic [irpfd_pkg::BYTE_W-1:0]       frame_byte2,
    output logic [irpfd_pkg::BYTE_W-1:0]       frame_byte3
);

    irpfd_pkg::window_cfg_t win_reg;

    logic                          in_vld_reg;
    logic [irpfd_pkg::TICK_W-1:0]  ticks_reg;

    logic                          receiving_reg, receiving_next;
    logic [2:0]                    bit_cnt_reg, bit_cnt_next;
    logic [1:0]                    byte_cnt_reg, byte_cnt_next;
    logic [irpfd_pkg::BYTE_W-1:0]  shift_reg, shift_next;
    logic [irpfd_pkg::BYTE_W-1:0]  store_reg [irpfd_pkg::NUM_STORE];

    logic                          out_valid_reg, out_valid_next;
    logic [irpfd_pkg::BYTE_W-1:0]  out_b0_reg, out_b1_reg, out_b2_reg, out_b3_reg;

    irpfd_pkg::pulse_class_t       cls;
    logic                          out_free;
    logic                          proc_fire;
    logic                          bit_ok;
    logic                          bit_val;
    logic                          byte_done;
    logic                          store_we;
    logic                          emit;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.zero_min   <= irpfd_pkg::RST_ZERO_MIN;
            win_reg.zero_max   <= irpfd_pkg::RST_ZERO_MAX;
            win_reg.one_min    <= irpfd_pkg::RST_ONE_MIN;
            win_reg.one_max    <= irpfd_pkg::RST_ONE_MAX;
            win_reg.leader_min <= irpfd_pkg::RST_LEADER_MIN;
            win_reg.leader_max <= irpfd_pkg::RST_LEADER_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                irpfd_pkg::CFG_ZERO_MIN:   win_reg.zero_min   <= cfg_data;
                irpfd_pkg::CFG_ZERO_MAX:   win_reg.zero_max   <= cfg_data;
                irpfd_pkg::CFG_ONE_MIN:    win_reg.one_min    <= cfg_data;
                irpfd_pkg::CFG_ONE_MAX:    win_reg.one_max    <= cfg_data;
                irpfd_pkg::CFG_LEADER_MIN: win_reg.leader_min <= cfg_data;
                irpfd_pkg::CFG_LEADER_MAX: win_reg.leader_max <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // handshake: the input stage drains whenever the result register can take a result
    assign out_free  = !out_valid_reg || out_ready;
    assign proc_fire = in_vld_reg && out_free;
    assign in_ready  = !in_vld_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ticks_reg <= high_ticks;
        end
    end

    irpfd_classify u_classify
    (
        .ticks (ticks_reg),
        .win   (win_reg),
        .cls   (cls)
    );

    // zero window wins when the windows overlap
    assign bit_ok    = cls.is_zero || cls.is_one;
    assign bit_val   = !cls.is_zero;
    assign byte_done = (bit_cnt_reg == irpfd_pkg::LAST_BIT);

    always_comb
    begin
        receiving_next = receiving_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        shift_next     = shift_reg;
        store_we       = 1'b0;
        emit           = 1'b0;
        if (proc_fire)
        begin
            if (!receiving_reg)
            begin
                if (cls.is_leader)
                begin
                    receiving_next = 1'b1;
                    bit_cnt_next   = 3'd0;
                    byte_cnt_next  = 2'd0;
                end
            end
            else if (!bit_ok)
            begin
                // abort, partial frame dropped
                receiving_next = 1'b0;
            end
            else
            begin
                shift_next = {shift_reg[irpfd_pkg::BYTE_W-2:0], bit_val};
                if (!byte_done)
                begin
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                end
                else
                begin
                    bit_cnt_next = 3'd0;
                    if (byte_cnt_reg != irpfd_pkg::LAST_BYTE)
                    begin
                        store_we      = 1'b1;
                        byte_cnt_next = byte_cnt_reg + 2'd1;
                    end
                    else
                    begin
                        emit           = 1'b1;
                        receiving_next = 1'b0;
                        byte_cnt_next  = 2'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            bit_cnt_reg   <= 3'd0;
            byte_cnt_reg  <= 2'd0;
        end
        else
        begin
            receiving_reg <= receiving_next;
            bit_cnt_reg   <= bit_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        for (int i = 0; i < irpfd_pkg::NUM_STORE; i++)
        begin
            if (store_we && (byte_cnt_reg == 2'(i)))
            begin
                store_reg[i] <= shift_next;
            end
        end
    end

    // result register
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_b0_reg <= store_reg[0];
            out_b1_reg <= store_reg[1];
            out_b2_reg <= store_reg[2];
            out_b3_reg <= shift_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_byte0 = out_b0_reg;
    assign frame_byte1 = out_b1_reg;
    assign frame_byte2 = out_b2_reg;
    assign frame_byte3 = out_b3_reg;

    // a new frame only appears at the end of the last byte of a reception
    a_emit_from_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (receiving_reg && byte_cnt_reg == irpfd_pkg::LAST_BYTE
                  && bit_cnt_reg == irpfd_pkg::LAST_BIT))
        else $error("frame emitted outside the last bit of the last byte");

    // after a frame the decoder is back in idle with a cleared byte counter
    a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid && !receiving_reg && byte_cnt_reg == 2'd0))
        else $error("decoder not idle after frame");

    // a loaded input stage never stalls while the result register is empty
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !out_valid_reg) |-> in_ready)
        else $error("input stalled with an empty result register");

endmodule

[tb/tb_ir_pulse_frame_decoder_core.sv]
// frame scoreboard and top-level testbench for the ir pulse frame decoder core

class frame_scoreboard;
    typedef logic [3:0][irpfd_pkg::BYTE_W-1:0] frame_t;

    irpfd_pkg::window_cfg_t win;
    bit                             receiving;
    logic [2:0]                     bit_cnt;
    logic [1:0]                     byte_cnt;
    logic [irpfd_pkg::BYTE_W-1:0]   shift_reg;
    logic [irpfd_pkg::BYTE_W-1:0]   stored [irpfd_pkg::NUM_STORE];
    frame_t                         expected_frames [$];
    int                             pulses_taken;
    int                             frames_predicted;
    int                             frames_checked;
    int                             mismatches;

    function new();
        win.zero_min   = irpfd_pkg::RST_ZERO_MIN;
        win.zero_max   = irpfd_pkg::RST_ZERO_MAX;
        win.one_min    = irpfd_pkg::RST_ONE_MIN;
        win.one_max    = irpfd_pkg::RST_ONE_MAX;
        win.leader_min = irpfd_pkg::RST_LEADER_MIN;
        win.leader_max = irpfd_pkg::RST_LEADER_MAX;
        receiving = 1'b0;
        bit_cnt = '0;
        byte_cnt = '0;
        shift_reg = '0;
        foreach (stored[i])
            stored[i] = '0;
        pulses_taken = 0;
        frames_predicted = 0;
        frames_checked = 0;
        mismatches = 0;
    endfunction

    function void set_window(logic [irpfd_pkg::CFG_IDX_W-1:0] idx,
                             logic [irpfd_pkg::CFG_W-1:0] val);
        case (idx)
            irpfd_pkg::CFG_ZERO_MIN:   win.zero_min = val;
            irpfd_pkg::CFG_ZERO_MAX:   win.zero_max = val;
            irpfd_pkg::CFG_ONE_MIN:    win.one_min = val;
            irpfd_pkg::CFG_ONE_MAX:    win.one_max = val;
            irpfd_pkg::CFG_LEADER_MIN: win.leader_min = val;
            irpfd_pkg::CFG_LEADER_MAX: win.leader_max = val;
            default: ;
        endcase
    endfunction

    static function bit in_window(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
        return (v > lo) && (v < hi);
    endfunction

    function int pending();
        return expected_frames.size();
    endfunction

    // called once per accepted input transaction
    function void note_pulse(logic [irpfd_pkg::TICK_W-1:0] t);
        logic b;
        if (!receiving)
        begin
            if (in_window(t, win.leader_min, win.leader_max))
            begin
                receiving = 1'b1;
                bit_cnt = '0;
                byte_cnt = '0;
                pulses_taken++;
            end
            return;
        end
        pulses_taken++;
        // zero window wins where the two bit windows overlap
        if (in_window(t, win.zero_min, win.zero_max))
            b = 1'b0;
        else if (in_window(t, win.one_min, win.one_max))
            b = 1'b1;
        else
        begin
            receiving = 1'b0;
            return;
        end
        shift_reg = {shift_reg[6:0], b};
        if (bit_cnt != irpfd_pkg::LAST_BIT)
        begin
            bit_cnt = bit_cnt + 3'd1;
            return;
        end
        bit_cnt = '0;
        if (byte_cnt != irpfd_pkg::LAST_BYTE)
        begin
            stored[byte_cnt] = shift_reg;
            byte_cnt = byte_cnt + 2'd1;
            return;
        end
        receiving = 1'b0;
        byte_cnt = '0;
        expected_frames.push_back({shift_reg, stored[2], stored[1], stored[0]});
        frames_predicted++;
    endfunction

    // called once per accepted output transaction
    function void check_frame(frame_t got);
        frame_t want;
        bit bad;
        if (expected_frames.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected frame: got %h %h %h %h",
                         got[0], got[1], got[2], got[3]);
            return;
        end
        want = expected_frames.pop_front();
        frames_checked++;
        bad = 1'b0;
        for (int k = 0; k < 4; k++)
            if (got[k] !== want[k])
                bad = 1'b1;
        if (bad)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("frame %0d mismatch: expected %h %h %h %h, got %h %h %h %h",
                         frames_checked, want[0], want[1], want[2], want[3],
                         got[0], got[1], got[2], got[3]);
        end
    endfunction
endclass

module tb_ir_pulse_frame_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_QUOTA  = 150;
    localparam int NUM_PHASES   = 8;
    localparam int MIN_FRAMES   = 40;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 8;
    localparam int NUM_DIRECTED = 22;

    // default windows: boundaries, idle strays, leader while receiving, aborts
    localparam logic [irpfd_pkg::TICK_W-1:0] DIRECTED_TICKS [NUM_DIRECTED] = '{
        8'd0, 8'd250, 8'd180, 8'd220, 8'd181, 8'd6, 8'd98, 8'd5,
        8'd219, 8'd39, 8'd40, 8'd200, 8'd200, 8'd190, 8'd99, 8'd185,
        8'd250, 8'd210, 8'd0, 8'd195, 8'd41, 8'd1
    };

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [irpfd_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [irpfd_pkg::CFG_W-1:0]        cfg_data;
    logic                               in_valid;
    logic                               in_ready;
    logic [irpfd_pkg::TICK_W-1:0]       high_ticks;
    logic                               out_valid;
    logic                               out_ready;
    logic [irpfd_pkg::BYTE_W-1:0]       frame_byte0;
    logic [irpfd_pkg::BYTE_W-1:0]       frame_byte1;
    logic [irpfd_pkg::BYTE_W-1:0]       frame_byte2;
    logic [irpfd_pkg::BYTE_W-1:0]       frame_byte3;

    frame_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  sent_count;
    bit  long_hold_req;

    ir_pulse_frame_decoder_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .high_ticks  (high_ticks),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_byte0 (frame_byte0),
        .frame_byte1 (frame_byte1),
        .frame_byte2 (frame_byte2),
        .frame_byte3 (frame_byte3)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(4_000_000);
        $display("FAIL ir_pulse_frame_decoder_core");
        $finish;
    end

    // result side: random stalls, plus one long hold-off counted here
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_frame({frame_byte3, frame_byte2, frame_byte1, frame_byte0});
    end

    task automatic send_pulse(input logic [irpfd_pkg::TICK_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        high_ticks <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_pulse(t);
        sent_count++;
    endtask

    function automatic logic [irpfd_pkg::TICK_W-1:0] pick_between(logic [7:0] lo,
                                                                  logic [7:0] hi);
        int l;
        int h;
        l = lo;
        h = hi;
        if (h > l + 1)
            return 8'($urandom_range(h - 1, l + 1));
        return 8'($urandom_range(250, 0));
    endfunction

    // mostly clean frames; some get a stray pulse first or break off early
    task automatic send_frame();
        logic b;
        int   stop_at;
        if ($urandom_range(3) == 0)
            send_pulse(8'($urandom_range(250, 0)));
        send_pulse(pick_between(sb.win.leader_min, sb.win.leader_max));
        stop_at = ($urandom_range(9) == 0) ? int'($urandom_range(31, 0)) : 32;
        for (int k = 0; k < 32; k++)
        begin
            if (k == stop_at)
            begin
                send_pulse(8'($urandom_range(250, 0)));
                break;
            end
            b = 1'($urandom_range(1, 0));
            if (b)
                send_pulse(pick_between(sb.win.one_min, sb.win.one_max));
            else
                send_pulse(pick_between(sb.win.zero_min, sb.win.zero_max));
        end
    endtask

    task automatic write_reg(input logic [irpfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [irpfd_pkg::CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_window(idx, val);
    endtask

    task automatic apply_windows(input irpfd_pkg::window_cfg_t w);
        write_reg(irpfd_pkg::CFG_ZERO_MIN, w.zero_min);
        write_reg(irpfd_pkg::CFG_ZERO_MAX, w.zero_max);
        write_reg(irpfd_pkg::CFG_ONE_MIN, w.one_min);
        write_reg(irpfd_pkg::CFG_ONE_MAX, w.one_max);
        write_reg(irpfd_pkg::CFG_LEADER_MIN, w.leader_min);
        write_reg(irpfd_pkg::CFG_LEADER_MAX, w.leader_max);
        cfg_we <= 1'b0;
    endtask

    // wait for every frame, then let the input register empty out
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic irpfd_pkg::window_cfg_t window_for(int p);
        irpfd_pkg::window_cfg_t w;
        case (p)
            1: w = '{zero_min: 8'd0, zero_max: 8'd2, one_min: 8'd248, one_max: 8'd250,
                     leader_min: 8'd124, leader_max: 8'd126};
            // bit windows overlap, zero has priority
            2: w = '{zero_min: 8'd0, zero_max: 8'd200, one_min: 8'd100, one_max: 8'd250,
                     leader_min: 8'd0, leader_max: 8'd250};
            // both bit windows empty: every frame aborts on its first bit
            3: w = '{zero_min: 8'd10, zero_max: 8'd11, one_min: 8'd250, one_max: 8'd0,
                     leader_min: 8'd180, leader_max: 8'd220};
            5: w = '{zero_min: 8'd50, zero_max: 8'd51, one_min: 8'd0, one_max: 8'd250,
                     leader_min: 8'd200, leader_max: 8'd250};
            4, 6:
            begin
                w.zero_min = 8'($urandom_range(200, 0));
                w.zero_max = 8'(w.zero_min + $urandom_range(50, 0));
                w.one_min = 8'($urandom_range(200, 0));
                w.one_max = 8'(w.one_min + $urandom_range(50, 0));
                w.leader_min = 8'($urandom_range(200, 0));
                w.leader_max = 8'(w.leader_min + $urandom_range(50, 2));
            end
            default: w = '{zero_min: irpfd_pkg::RST_ZERO_MIN,
                           zero_max: irpfd_pkg::RST_ZERO_MAX,
                           one_min: irpfd_pkg::RST_ONE_MIN,
                           one_max: irpfd_pkg::RST_ONE_MAX,
                           leader_min: irpfd_pkg::RST_LEADER_MIN,
                           leader_max: irpfd_pkg::RST_LEADER_MAX};
        endcase
        return w;
    endfunction

    initial
    begin
        int phase_taken;
        int phase_sent;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = irpfd_pkg::CFG_ZERO_MIN;
        cfg_data = '0;
        in_valid = 1'b0;
        high_ticks = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sent_count = 0;
        long_hold_req = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_pulse(DIRECTED_TICKS[i]);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p != 0)
            begin
                drain();
                apply_windows(window_for(p));
            end
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 52;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 52;
                end
                default:
                begin
                    send_idle_pct = 14;
                    recv_stall_pct = 14;
                end
            endcase
            // block the result side while frames keep coming, so the core backs up
            if (p == 0)
                long_hold_req = 1'b1;
            phase_taken = sb.pulses_taken;
            phase_sent = sent_count;
            while (((sb.pulses_taken - phase_taken < PHASE_QUOTA) &&
                    (sent_count - phase_sent < 4 * PHASE_QUOTA)) ||
                   ((p == NUM_PHASES - 1) && (sb.frames_predicted < MIN_FRAMES)))
                send_frame();
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d decoded pulses and %0d frames across %0d window settings,",
                 sb.pulses_taken, sb.frames_checked, NUM_PHASES);
        $display("with idle and stall mixes and a %0d-cycle output hold-off; %0d mismatches",
                 LONG_HOLD, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS ir_pulse_frame_decoder_core");
        else
            $display("FAIL ir_pulse_frame_decoder_core");
        $finish;
    end
endmodule

[sim.f]
design/irpfd_pkg.sv
design/irpfd_classify.sv
design/ir_pulse_frame_decoder_core.sv
tb/tb_ir_pulse_frame_decoder_core.sv
